/* design/rrc_pkg.sv */
// Relay request controller package: codes, payload structs and controller types.
// No dependencies; every other design file but rrc_if imports it.
package rrc_pkg;

  localparam int RELAYS     = 4;
  localparam int INHIBITORS = 16;
  localparam int RID_W      = (RELAYS > 1) ? $clog2(RELAYS) : 1;
  localparam int INCH_REGS  = 4;

  // Opcodes
  localparam logic [3:0] OP_TOGGLE = 4'd0;
  localparam logic [3:0] OP_ON     = 4'd1;
  localparam logic [3:0] OP_OFF    = 4'd2;
  localparam logic [3:0] OP_PULSE  = 4'd3;
  localparam logic [3:0] OP_TIMED  = 4'd4;
  localparam logic [3:0] OP_INHIB  = 4'd5;
  localparam logic [3:0] OP_REL    = 4'd6;
  localparam logic [3:0] OP_CANCEL = 4'd7;

  // Request sources
  localparam logic [1:0] SRC_INTERLOCK = 2'd3;

  // Status codes
  localparam logic [2:0] ST_APPLIED   = 3'd0;
  localparam logic [2:0] ST_UNCHANGED = 3'd1;
  localparam logic [2:0] ST_DEFERRED  = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_HOUSE     = 3'd5;

  // Timer actions
  localparam logic [1:0] TA_NONE    = 2'd0;
  localparam logic [1:0] TA_CANCEL  = 2'd1;
  localparam logic [1:0] TA_RESTART = 2'd2;

  // Interlock actions
  localparam logic [1:0] IA_NONE       = 2'd0;
  localparam logic [1:0] IA_PREPARE    = 2'd1;
  localparam logic [1:0] IA_CANCEL     = 2'd2;
  localparam logic [1:0] IA_CANCEL_OFF = 2'd3;

  // Auto-off reasons
  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_PULSE = 2'd1;
  localparam logic [1:0] RS_TIMED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RELAY_COUNT = 3'd0;
  localparam logic [2:0] CFG_INCHING_0   = 3'd1;
  localparam logic [2:0] CFG_INCHING_3   = 3'd4;

  typedef logic [INHIBITORS-1:0] inh_vec_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [3:0]  relay_num;
    logic [1:0]  source;
    logic [31:0] on_ms;
    logic        interlock_clear;
    logic [15:0] relay_bits;
    logic [4:0]  inhibitor;
  } rrc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        drive_write;
    logic        drive_on;
    logic [1:0]  timer_action;
    logic [31:0] timer_ms;
    logic [1:0]  interlock_action;
    logic        notify;
    logic [1:0]  notify_source;
    logic [1:0]  auto_off_kind;
    logic        mask_changed;
  } rrc_rsp_t;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } rrc_state_t;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic commit;   // update the record and load the result register
    logic taken;    // result taken by the receiver
  } rrc_cmd_t;

  typedef struct packed {
    logic out_valid;
  } rrc_stat_t;

endpackage

/* design/rrc_if.sv */
// Request and response channel interfaces of the relay request controller.
// Depends on nothing; payload fields are plain signals.
interface rrc_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [3:0]  relay_num;
  logic [1:0]  origin;
  logic [31:0] on_ms;
  logic        interlock_clear;
  logic [15:0] relay_bits;
  logic [4:0]  inhibitor;

  modport source (output valid, opcode, relay_num, origin, on_ms, interlock_clear,
                  relay_bits, inhibitor, input ready);
  modport sink (input valid, opcode, relay_num, origin, on_ms, interlock_clear,
                relay_bits, inhibitor, output ready);
endinterface

interface rrc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        drive_write;
  logic        drive_on;
  logic [1:0]  timer_action;
  logic [31:0] timer_ms;
  logic [1:0]  interlock_action;
  logic        notify;
  logic [1:0]  notify_source;
  logic [1:0]  auto_off_kind;
  logic        mask_changed;

  modport source (output valid, status, drive_write, drive_on, timer_action, timer_ms,
                  interlock_action, notify, notify_source, auto_off_kind, mask_changed,
                  input ready);
  modport sink (input valid, status, drive_write, drive_on, timer_action, timer_ms,
                interlock_action, notify, notify_source, auto_off_kind, mask_changed,
                output ready);
endinterface

/* design/rrc_ctrl.sv */
// Sequencer of the relay request controller: accept, then execute one item.
// Depends on rrc_pkg.
module rrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  rrc_pkg::rrc_stat_t stat,
  output rrc_pkg::rrc_cmd_t  cmd
);
  import rrc_pkg::*;

  rrc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    cmd.taken   = stat.out_valid & out_ready;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // hold until the result register is free or being emptied
        if (!stat.out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

endmodule

/* design/rrc_dp.sv */
// Datapath of the relay request controller: registers, relay records, request
// decode and result register. Depends on rrc_pkg.
module rrc_dp (
  input  logic              clk,
  input  logic              rst,
  input  rrc_pkg::rrc_cmd_t  cmd,
  output rrc_pkg::rrc_stat_t stat,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  rrc_pkg::rrc_req_t  req_in,
  output rrc_pkg::rrc_rsp_t  rsp_out
);
  import rrc_pkg::*;

  // configuration
  logic [2:0]  relay_count;
  logic [15:0] inching [INCH_REGS];

  // relay records
  logic        relay_on       [RELAYS];
  logic        relay_applied  [RELAYS];
  inh_vec_t    inhibit_bits   [RELAYS];
  logic [1:0]  off_reason     [RELAYS];
  logic        deferred_pend  [RELAYS];
  logic [1:0]  deferred_rsn   [RELAYS];
  logic [31:0] deferred_delay [RELAYS];

  rrc_req_t req_q;
  rrc_rsp_t rsp_q;
  logic     out_valid;

  // decode of the held item
  logic             valid_id;
  logic [RID_W-1:0] rid;
  logic             cur_on, cur_app, cur_pend;
  inh_vec_t         cur_inh;
  logic [1:0]       cur_offr, cur_drsn;
  logic [31:0]      cur_ddly;
  logic [31:0]      inch_sel;
  logic             target, ok, changed;
  logic [31:0]      ms, ms_e;
  logic [1:0]       reason, reason_e;
  inh_vec_t         inh_bit;
  logic             rec_we;
  logic             on_next, app_next, pend_next;
  logic [1:0]       offr_next, drsn_next;
  logic [31:0]      ddly_next;
  inh_vec_t         inh_next [RELAYS];
  logic             inh_we;
  rrc_rsp_t         rsp_next;
  logic [2:0]       cnt_next;

  assign valid_id = req_q.relay_num < 4'(relay_count);
  assign rid      = req_q.relay_num[RID_W-1:0];
  assign cur_on   = relay_on[rid];
  assign cur_app  = relay_applied[rid];
  assign cur_pend = deferred_pend[rid];
  assign cur_inh  = inhibit_bits[rid];
  assign cur_offr = off_reason[rid];
  assign cur_drsn = deferred_rsn[rid];
  assign cur_ddly = deferred_delay[rid];
  assign inch_sel = (req_q.relay_num < 4'(INCH_REGS)) ?
                    {16'd0, inching[req_q.relay_num[1:0]]} : 32'd0;
  assign inh_bit  = INHIBITORS'(1) << req_q.inhibitor;

  always_comb begin
    target = 1'b0;
    ok     = 1'b1;
    ms     = 32'd0;
    reason = RS_NONE;
    case (req_q.opcode)
      OP_TOGGLE: target = ~cur_on;
      OP_ON:     target = 1'b1;
      OP_OFF:    target = 1'b0;
      OP_PULSE: begin
        ms     = (req_q.on_ms != 32'd0) ? req_q.on_ms : inch_sel;
        ok     = (ms != 32'd0);
        target = 1'b1;
        reason = RS_PULSE;
      end
      default: begin
        target = 1'b1;
        ms     = req_q.on_ms;
        reason = RS_TIMED;
      end
    endcase
  end

  always_comb begin
    rsp_next        = '0;
    rsp_next.status = ST_INVALID;
    rec_we    = 1'b0;
    on_next   = cur_on;
    app_next  = cur_app;
    pend_next = cur_pend;
    offr_next = cur_offr;
    drsn_next = cur_drsn;
    ddly_next = cur_ddly;
    reason_e  = reason;
    ms_e      = ms;
    changed   = cur_on != target;
    inh_we    = 1'b0;
    for (int r = 0; r < RELAYS; r++) begin
      inh_next[r] = inhibit_bits[r];
    end

    if (req_q.opcode <= OP_TIMED && valid_id) begin
      if (!ok) begin
        rsp_next.status = ST_INVALID;
      end else if (target && cur_inh != '0) begin
        rsp_next.status = ST_BLOCKED;
      end else begin
        rec_we = 1'b1;
        if (req_q.source == SRC_INTERLOCK) begin
          // interlock completion resumes the saved switch-on
          if (cur_pend) begin
            reason_e  = cur_drsn;
            ms_e      = cur_ddly;
            pend_next = 1'b0;
          end
        end else begin
          pend_next = 1'b0;
        end
        rsp_next.timer_action = TA_CANCEL;
        offr_next = reason_e;
        if (cur_app && cur_on == target) begin
          if (reason_e != RS_NONE) begin
            rsp_next.timer_action = TA_RESTART;
            rsp_next.timer_ms     = ms_e;
          end
          rsp_next.status = ST_UNCHANGED;
        end else if (target && !req_q.interlock_clear) begin
          rsp_next.interlock_action = IA_PREPARE;
          drsn_next = reason_e;
          ddly_next = ms_e;
          pend_next = 1'b1;
          rsp_next.status = ST_DEFERRED;
        end else begin
          if (!target) begin
            pend_next = 1'b0;
            rsp_next.interlock_action = changed ? IA_CANCEL_OFF : IA_CANCEL;
          end else begin
            rsp_next.interlock_action = IA_PREPARE;
          end
          if (reason_e != RS_NONE) begin
            rsp_next.timer_action = TA_RESTART;
            rsp_next.timer_ms     = ms_e;
          end
          on_next  = target;
          app_next = 1'b1;
          rsp_next.drive_write = 1'b1;
          rsp_next.drive_on    = target;
          if (changed) begin
            rsp_next.notify        = 1'b1;
            rsp_next.notify_source = req_q.source;
          end
          rsp_next.status = ST_APPLIED;
        end
      end
      rsp_next.auto_off_kind = offr_next;
    end else if (req_q.opcode == OP_INHIB || req_q.opcode == OP_REL) begin
      if (req_q.inhibitor < 5'(INHIBITORS)) begin
        inh_we = 1'b1;
        for (int r = 0; r < RELAYS; r++) begin
          if (r < int'(relay_count) && req_q.relay_bits[r]) begin
            inh_next[r] = (req_q.opcode == OP_INHIB) ? (inhibit_bits[r] | inh_bit)
                                                     : (inhibit_bits[r] & ~inh_bit);
            rsp_next.mask_changed = 1'b1;
          end
        end
        rsp_next.status = ST_HOUSE;
      end
    end else if (req_q.opcode == OP_CANCEL) begin
      if (valid_id) begin
        rec_we    = 1'b1;
        pend_next = 1'b0;
        rsp_next.auto_off_kind = cur_offr;
        rsp_next.status        = ST_HOUSE;
      end
    end
  end

  // clamp the relay count to the records that exist
  assign cnt_next = (int'(cfg_data[2:0]) > RELAYS) ? 3'(RELAYS) : cfg_data[2:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_in;
    end
    if (cmd.commit) begin
      rsp_q <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      relay_count <= 3'd0;
      for (int i = 0; i < INCH_REGS; i++) begin
        inching[i] <= 16'd0;
      end
      for (int r = 0; r < RELAYS; r++) begin
        relay_on[r]       <= 1'b0;
        relay_applied[r]  <= 1'b0;
        inhibit_bits[r]   <= '0;
        off_reason[r]     <= RS_NONE;
        deferred_pend[r]  <= 1'b0;
        deferred_rsn[r]   <= RS_NONE;
        deferred_delay[r] <= 32'd0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (cmd.taken) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit && rec_we) begin
        relay_on[rid]       <= on_next;
        relay_applied[rid]  <= app_next;
        off_reason[rid]     <= offr_next;
        deferred_pend[rid]  <= pend_next;
        deferred_rsn[rid]   <= drsn_next;
        deferred_delay[rid] <= ddly_next;
      end
      if (cmd.commit && inh_we) begin
        for (int r = 0; r < RELAYS; r++) begin
          inhibit_bits[r] <= inh_next[r];
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_RELAY_COUNT) begin
          // clear the records of relays that become enabled
          for (int r = 0; r < RELAYS; r++) begin
            if (r >= int'(relay_count) && r < int'(cnt_next)) begin
              relay_on[r]       <= 1'b0;
              relay_applied[r]  <= 1'b0;
              inhibit_bits[r]   <= '0;
              off_reason[r]     <= RS_NONE;
              deferred_pend[r]  <= 1'b0;
              deferred_rsn[r]   <= RS_NONE;
              deferred_delay[r] <= 32'd0;
            end
          end
          relay_count <= cnt_next;
        end else if (cfg_index >= CFG_INCHING_0 && cfg_index <= CFG_INCHING_3) begin
          inching[2'(cfg_index - CFG_INCHING_0)] <= cfg_data;
        end
      end
    end
  end

  assign stat.out_valid = out_valid;
  assign rsp_out        = rsp_q;

endmodule

/* design/relay_request_controller.sv */
// Top level of the relay request controller: channels, config port, sequencer
// and datapath. Depends on rrc_pkg, rrc_if, rrc_ctrl and rrc_dp.
//
// Usage:
//   req  - request channel (valid/ready); one item is one relay request:
//          toggle, on, off, pulse, timed on, inhibit, release, cancel deferred.
//   rsp  - result channel (valid/ready); exactly one result item per request,
//          carrying status, drive command, timer and interlock actions and a
//          change notice for the external driver, timer and observers.
//   cfg  - write-only register port (cfg_we, cfg_index, cfg_data): relay count
//          at index 0, inching times of relays 0..3 at indexes 1..4. Write only
//          while no request is in flight.
// Timing: a request is latched on accept and executed in the execute state, once
//   the result register is free; there the relay record is read, modified and
//   written back and the result register is loaded. The sequencer alternates
//   accept and execute around the single record read-modify-write, so a new
//   request is not accepted until the last one has executed.
// Stall: the result register holds its item until taken; the next request is
//   accepted meanwhile, and its execute step waits for the register to free.
// Reset (rst, synchronous): relay count and inching times go to zero, every
//   relay record is cleared, and no result is pending.
module relay_request_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  rrc_req_if.sink     req,
  rrc_rsp_if.source   rsp
);
  import rrc_pkg::*;

  rrc_cmd_t  cmd;
  rrc_stat_t stat;
  rrc_req_t  req_in;
  rrc_rsp_t  rsp_out;

  // pack the request channel fields
  assign req_in.opcode          = req.opcode;
  assign req_in.relay_num       = req.relay_num;
  assign req_in.source          = req.origin;
  assign req_in.on_ms           = req.on_ms;
  assign req_in.interlock_clear = req.interlock_clear;
  assign req_in.relay_bits      = req.relay_bits;
  assign req_in.inhibitor       = req.inhibitor;

  rrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_in    (req_in),
    .rsp_out   (rsp_out)
  );

  // drive the result channel from the result register
  assign rsp.valid            = stat.out_valid;
  assign rsp.status           = rsp_out.status;
  assign rsp.drive_write      = rsp_out.drive_write;
  assign rsp.drive_on         = rsp_out.drive_on;
  assign rsp.timer_action     = rsp_out.timer_action;
  assign rsp.timer_ms         = rsp_out.timer_ms;
  assign rsp.interlock_action = rsp_out.interlock_action;
  assign rsp.notify           = rsp_out.notify;
  assign rsp.notify_source    = rsp_out.notify_source;
  assign rsp.auto_off_kind    = rsp_out.auto_off_kind;
  assign rsp.mask_changed     = rsp_out.mask_changed;

endmodule
